// ===== rtl/core/scpt_pkg.sv =====
// ----------------------------------------------------------------------------
// scpt_pkg
// Types, constants and the prefix mask helper for the sorted CIDR table.
// ----------------------------------------------------------------------------
package scpt_pkg;

    localparam int MaxEntries = 255;

    localparam logic [1:0] ActAdd    = 2'd0;
    localparam logic [1:0] ActDelete = 2'd1;
    localparam logic [1:0] ActLookup = 2'd2;
    localparam logic [1:0] ActNone   = 2'd3;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StFull     = 2'd1;
    localparam logic [1:0] StBadPfx   = 2'd2;
    localparam logic [1:0] StNotFound = 2'd3;

    localparam logic [7:0] V4MaxPfx = 8'd32;
    localparam logic [7:0] V6MaxPfx = 8'd128;

    typedef struct packed {
        logic [1:0]  action;
        logic        is_ipv6;
        logic [63:0] address_hi;
        logic [63:0] address_lo;
        logic [7:0]  prefix_len;
        logic [15:0] new_priority;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        matched;
        logic [15:0] found_priority;
        logic [7:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  pfx;
        logic [15:0] prio;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_WAIT,
        S_CMP,
        S_SHUP_RD,
        S_SHUP_WR,
        S_INS,
        S_SHDN_RD,
        S_SHDN_WR,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        C_CONT,
        C_INS,
        C_EXACT,
        C_SUB
    } t_cmp;

    // left-aligned 128-bit mask of n ones, n in 0..128
    function automatic logic [127:0] pfx_mask(input logic [7:0] n);
        logic [127:0] m;
        m = '1;
        if (n == 8'd0) begin
            m = '0;
        end else if (n < 8'd128) begin
            m = ~('1 >> n);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/sorted_cidr_priority_table.sv =====
// Flow: the item scans the slots of its IPv4 or IPv6 section one by one; an add
// that inserts then shifts later slots up and writes the new slot, a delete that
// hits shifts them down, and the result waits on the output handshake.
// Throughput: one item at a time; ready only in idle. The slot memory, with one
// read and one write port, and the shared 128-bit masked compare set the figure.
// Reset: sync active low clears counts and control; slot memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_cidr_priority_table
// Sorted IPv4/IPv6 prefix table with add, delete and a lookup that returns the last matching entry in table order.
// ----------------------------------------------------------------------------
module sorted_cidr_priority_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  scpt_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output scpt_pkg::t_out_item  o_data
);

    scpt_pkg::t_slot r_mem [scpt_pkg::MaxEntries];
    scpt_pkg::t_slot r_rd;

    scpt_pkg::t_state r_state, n_state;
    scpt_pkg::t_in_item r_item;
    logic [127:0] r_key;
    logic [7:0]   r_apfx;
    logic [7:0]   r_idx, r_hi, r_k, r_used, r_v4;
    logic [1:0]   r_status;
    logic         r_matched;
    logic [15:0]  r_found;

    logic         mem_we;
    logic [7:0]   mem_wa, mem_ra;
    scpt_pkg::t_slot mem_wd;

    logic [7:0]   n_pfx;
    logic [127:0] mask, xk, yk;
    scpt_pkg::t_cmp cmp;
    logic         key_v6;
    logic [7:0]   maxpfx;
    logic         bad_pfx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    assign key_v6 = i_data.is_ipv6;
    assign maxpfx = key_v6 ? scpt_pkg::V6MaxPfx : scpt_pkg::V4MaxPfx;
    assign bad_pfx = (i_data.prefix_len == 8'd0) || (i_data.prefix_len > maxpfx);

    // shared masked compare
    always_comb begin
        n_pfx = (r_apfx < r_rd.pfx) ? r_apfx : r_rd.pfx;
        mask  = scpt_pkg::pfx_mask(n_pfx);
        xk    = r_key & mask;
        yk    = {r_rd.hi, r_rd.lo} & mask;
        if (xk < yk) begin
            cmp = scpt_pkg::C_INS;
        end else if (xk > yk) begin
            cmp = scpt_pkg::C_CONT;
        end else if (r_apfx == r_rd.pfx) begin
            cmp = scpt_pkg::C_EXACT;
        end else if (r_apfx > r_rd.pfx) begin
            cmp = scpt_pkg::C_SUB;
        end else begin
            cmp = scpt_pkg::C_CONT;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scpt_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_data.action == scpt_pkg::ActNone ||
                        (i_data.action != scpt_pkg::ActLookup && bad_pfx)) begin
                        n_state = scpt_pkg::S_OUT;
                    end else begin
                        n_state = scpt_pkg::S_RD;
                    end
                end
            end
            scpt_pkg::S_RD: begin
                if (r_idx >= r_hi) begin
                    if (r_item.action == scpt_pkg::ActAdd) begin
                        n_state = (r_used == 8'(scpt_pkg::MaxEntries)) ?
                                  scpt_pkg::S_OUT : scpt_pkg::S_SHUP_RD;
                    end else begin
                        n_state = scpt_pkg::S_OUT;
                    end
                end else begin
                    n_state = scpt_pkg::S_WAIT;
                end
            end
            scpt_pkg::S_WAIT: n_state = scpt_pkg::S_CMP;
            scpt_pkg::S_CMP: begin
                if (r_item.action == scpt_pkg::ActLookup || cmp == scpt_pkg::C_CONT) begin
                    n_state = scpt_pkg::S_RD;
                end else if (r_item.action == scpt_pkg::ActAdd) begin
                    if (cmp == scpt_pkg::C_EXACT ||
                        r_used == 8'(scpt_pkg::MaxEntries)) begin
                        n_state = scpt_pkg::S_OUT;
                    end else begin
                        n_state = scpt_pkg::S_SHUP_RD;
                    end
                end else begin
                    n_state = (cmp == scpt_pkg::C_EXACT) ?
                              scpt_pkg::S_SHDN_RD : scpt_pkg::S_OUT;
                end
            end
            scpt_pkg::S_SHUP_RD: begin
                n_state = (r_k > r_idx) ? scpt_pkg::S_SHUP_WR : scpt_pkg::S_INS;
            end
            scpt_pkg::S_SHUP_WR: n_state = scpt_pkg::S_SHUP_RD;
            scpt_pkg::S_INS:     n_state = scpt_pkg::S_OUT;
            scpt_pkg::S_SHDN_RD: begin
                n_state = (9'(r_k) + 9'd1 < 9'(r_used)) ?
                          scpt_pkg::S_SHDN_WR : scpt_pkg::S_OUT;
            end
            scpt_pkg::S_SHDN_WR: n_state = scpt_pkg::S_SHDN_RD;
            scpt_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = scpt_pkg::S_IDLE;
                end
            end
            default: n_state = scpt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_k;
        mem_wd = r_rd;
        mem_ra = r_idx;
        unique case (r_state)
            scpt_pkg::S_CMP: begin
                if (r_item.action == scpt_pkg::ActAdd && cmp == scpt_pkg::C_EXACT) begin
                    mem_we = 1'b1;
                    mem_wa = r_idx;
                    mem_wd = {r_rd.hi, r_rd.lo, r_rd.pfx, r_item.new_priority};
                end
            end
            scpt_pkg::S_SHUP_RD: mem_ra = r_k - 8'd1;
            scpt_pkg::S_SHUP_WR: mem_we = 1'b1;
            scpt_pkg::S_INS: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = {r_key, r_apfx, r_item.new_priority};
            end
            scpt_pkg::S_SHDN_RD: mem_ra = r_k + 8'd1;
            scpt_pkg::S_SHDN_WR: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= scpt_pkg::S_IDLE;
            r_used    <= '0;
            r_v4      <= '0;
            r_status  <= scpt_pkg::StOk;
            r_matched <= 1'b0;
            r_found   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                scpt_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_item    <= i_data;
                        r_matched <= 1'b0;
                        r_found   <= '0;
                        r_status  <= scpt_pkg::StOk;
                        if (key_v6) begin
                            r_key <= {i_data.address_hi, i_data.address_lo};
                            r_idx <= r_v4;
                            r_hi  <= r_used;
                        end else begin
                            r_key <= {i_data.address_lo[31:0], 96'd0};
                            r_idx <= '0;
                            r_hi  <= r_v4;
                        end
                        r_apfx <= (i_data.action == scpt_pkg::ActLookup) ? maxpfx :
                                  i_data.prefix_len;
                        if (i_data.action != scpt_pkg::ActLookup &&
                            i_data.action != scpt_pkg::ActNone && bad_pfx) begin
                            r_status <= scpt_pkg::StBadPfx;
                        end
                    end
                end
                scpt_pkg::S_RD: begin
                    r_k <= r_used;
                    if (r_idx >= r_hi) begin
                        if (r_item.action == scpt_pkg::ActDelete) begin
                            r_status <= scpt_pkg::StNotFound;
                        end else if (r_item.action == scpt_pkg::ActAdd &&
                                     r_used == 8'(scpt_pkg::MaxEntries)) begin
                            r_status <= scpt_pkg::StFull;
                        end
                    end
                end
                scpt_pkg::S_CMP: begin
                    r_k <= (r_item.action == scpt_pkg::ActDelete) ? r_idx : r_used;
                    if (r_item.action == scpt_pkg::ActLookup) begin
                        if (cmp == scpt_pkg::C_EXACT || cmp == scpt_pkg::C_SUB) begin
                            r_matched <= 1'b1;
                            r_found   <= r_rd.prio;
                        end
                        r_idx <= r_idx + 8'd1;
                    end else if (cmp == scpt_pkg::C_CONT) begin
                        r_idx <= r_idx + 8'd1;
                    end else if (r_item.action == scpt_pkg::ActAdd) begin
                        if (cmp != scpt_pkg::C_EXACT &&
                            r_used == 8'(scpt_pkg::MaxEntries)) begin
                            r_status <= scpt_pkg::StFull;
                        end
                    end else if (cmp != scpt_pkg::C_EXACT) begin
                        r_status <= scpt_pkg::StNotFound;
                    end
                end
                scpt_pkg::S_SHUP_WR: r_k <= r_k - 8'd1;
                scpt_pkg::S_INS: begin
                    r_used <= r_used + 8'd1;
                    if (!r_item.is_ipv6) begin
                        r_v4 <= r_v4 + 8'd1;
                    end
                end
                scpt_pkg::S_SHDN_RD: begin
                    if (!(9'(r_k) + 9'd1 < 9'(r_used))) begin
                        r_used <= r_used - 8'd1;
                        if (r_idx < r_v4) begin
                            r_v4 <= r_v4 - 8'd1;
                        end
                    end
                end
                scpt_pkg::S_SHDN_WR: r_k <= r_k + 8'd1;
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == scpt_pkg::S_IDLE);
    assign o_valid = (r_state == scpt_pkg::S_OUT);
    assign o_data  = {r_status, r_matched, r_found, r_used};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the sorted CIDR priority table against a scoreboard that keeps its
// own copy of the prefix table. Directed items hit the prefix-length limits,
// nesting, update, delete and miss cases. Random items fill the table to full
// and drain it again, with random stalls on both handshakes.
// ----------------------------------------------------------------------------
class prefix_table_scoreboard;
    bit [127:0]  key_q[scpt_pkg::MaxEntries];
    bit [7:0]    len_q[scpt_pkg::MaxEntries];
    bit [15:0]   prio_q[scpt_pkg::MaxEntries];
    int unsigned used;
    int unsigned v4cnt;
    scpt_pkg::t_out_item expected_q[$];
    int          errors;

    function scpt_pkg::t_cmp compare(bit [127:0] k, int unsigned kl, int unsigned j);
        int unsigned n;
        bit [127:0]  m;
        n = (kl < len_q[j]) ? kl : len_q[j];
        m = ~({128{1'b1}} >> n);
        if ((k & m) < (key_q[j] & m)) return scpt_pkg::C_INS;
        if ((k & m) > (key_q[j] & m)) return scpt_pkg::C_CONT;
        if (kl == len_q[j]) return scpt_pkg::C_EXACT;
        if (kl > len_q[j]) return scpt_pkg::C_SUB;
        return scpt_pkg::C_CONT;
    endfunction

    function void note_input(scpt_pkg::t_in_item it);
        scpt_pkg::t_out_item r;
        bit [127:0]  k;
        int unsigned maxp, lo_i, hi_i, pos, pl;
        scpt_pkg::t_cmp c;
        bit          done;
        r = '0;
        k = it.is_ipv6 ? {it.address_hi, it.address_lo} : {it.address_lo[31:0], 96'b0};
        maxp = it.is_ipv6 ? 128 : 32;
        lo_i = it.is_ipv6 ? v4cnt : 0;
        hi_i = it.is_ipv6 ? used : v4cnt;
        pl = it.prefix_len;
        c = scpt_pkg::C_CONT;
        if (it.action == scpt_pkg::ActLookup) begin
            for (int unsigned i = lo_i; i < hi_i; i++) begin
                c = compare(k, maxp, i);
                if (c == scpt_pkg::C_EXACT || c == scpt_pkg::C_SUB) begin
                    r.matched = 1'b1;
                    r.found_priority = prio_q[i];
                end
            end
        end else if (it.action == scpt_pkg::ActAdd || it.action == scpt_pkg::ActDelete) begin
            if (pl == 0 || pl > maxp) begin
                r.status = scpt_pkg::StBadPfx;
            end else begin
                done = 0;
                pos = hi_i;
                for (int unsigned i = lo_i; i < hi_i; i++) begin
                    c = compare(k, pl, i);
                    if (c != scpt_pkg::C_CONT) begin
                        done = 1;
                        pos = i;
                        break;
                    end
                end
                if (it.action == scpt_pkg::ActAdd) begin
                    if (done && c == scpt_pkg::C_EXACT) begin
                        prio_q[pos] = it.new_priority;
                    end else if (used >= scpt_pkg::MaxEntries) begin
                        r.status = scpt_pkg::StFull;
                    end else begin
                        for (int unsigned j = used; j > pos; j--) begin
                            key_q[j] = key_q[j-1];
                            len_q[j] = len_q[j-1];
                            prio_q[j] = prio_q[j-1];
                        end
                        key_q[pos] = k;
                        len_q[pos] = pl[7:0];
                        prio_q[pos] = it.new_priority;
                        used++;
                        if (!it.is_ipv6) v4cnt++;
                    end
                end else if (done && c == scpt_pkg::C_EXACT) begin
                    for (int unsigned j = pos; j + 1 < used; j++) begin
                        key_q[j] = key_q[j+1];
                        len_q[j] = len_q[j+1];
                        prio_q[j] = prio_q[j+1];
                    end
                    if (pos < v4cnt) v4cnt--;
                    used--;
                end else begin
                    r.status = scpt_pkg::StNotFound;
                end
            end
        end
        r.occupancy = used[7:0];
        expected_q.push_back(r);
    endfunction

    function void check_result(scpt_pkg::t_out_item got);
        scpt_pkg::t_out_item e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (got.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
            errors++;
        end
        if (got.matched !== e.matched) begin
            $display("%0t: matched exp %0d got %0d", $time, e.matched, got.matched);
            errors++;
        end
        if (got.found_priority !== e.found_priority) begin
            $display("%0t: found_priority exp %h got %h", $time, e.found_priority,
                     got.found_priority);
            errors++;
        end
        if (got.occupancy !== e.occupancy) begin
            $display("%0t: occupancy exp %0d got %0d", $time, e.occupancy, got.occupancy);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int CycleLimit = 4000000;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    logic      i_ready = 0;
    logic      o_ready;
    logic      o_valid;
    scpt_pkg::t_in_item  i_data = '0;
    scpt_pkg::t_out_item o_data;

    prefix_table_scoreboard sb = new();
    scpt_pkg::t_in_item  known_q[$];
    bit        no_idle = 0;
    int        cycles = 0;

    sorted_cidr_priority_table DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
        i_ready <= no_idle || ($urandom_range(99) >= 24);
    end

    task automatic send(scpt_pkg::t_in_item it);
        if (!no_idle && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(it);
        if (it.action == scpt_pkg::ActAdd) known_q.push_back(it);
    endtask

    function automatic scpt_pkg::t_in_item make_item(bit [1:0] act, bit v6, bit [63:0] hi,
                                          bit [63:0] lo, bit [7:0] pl, bit [15:0] pr);
        scpt_pkg::t_in_item it;
        it.action = act;
        it.is_ipv6 = v6;
        it.address_hi = hi;
        it.address_lo = lo;
        it.prefix_len = pl;
        it.new_priority = pr;
        return it;
    endfunction

    function automatic scpt_pkg::t_in_item random_item(int add_pct, int del_pct,
                                                       int reuse_pct);
        scpt_pkg::t_in_item it;
        int       r;
        bit [7:0] maxp;
        r = $urandom_range(99);
        if (known_q.size() > 0 && $urandom_range(99) < reuse_pct) begin
            it = known_q[$urandom_range(known_q.size() - 1)];
            if ($urandom_range(3) == 0) it.address_lo[15:0] = $urandom;
            it.new_priority = $urandom;
        end else begin
            it.is_ipv6 = $urandom_range(1);
            it.address_hi = {$urandom, $urandom};
            it.address_lo = {$urandom, $urandom};
            // narrow top bits so prefixes nest and collide
            it.address_hi[63:60] = $urandom_range(3);
            it.address_lo[31:28] = $urandom_range(3);
            maxp = it.is_ipv6 ? scpt_pkg::V6MaxPfx : scpt_pkg::V4MaxPfx;
            it.prefix_len = $urandom_range(maxp, 1);
            if ($urandom_range(29) == 0) it.prefix_len = $urandom;
            if ($urandom_range(29) == 0) it.prefix_len = 0;
            it.new_priority = $urandom;
        end
        if (r < add_pct) it.action = scpt_pkg::ActAdd;
        else if (r < add_pct + del_pct) it.action = scpt_pkg::ActDelete;
        else if (r < 97) it.action = scpt_pkg::ActLookup;
        else it.action = scpt_pkg::ActNone;
        return it;
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(make_item(scpt_pkg::ActLookup, 0, 0, 64'h0a01_0203, 0, 0));
        send(make_item(scpt_pkg::ActDelete, 0, 0, 64'h0a00_0000, 8, 0));
        send(make_item(scpt_pkg::ActAdd, 0, '1, 64'h0a00_0000, 8, 16'h0011));
        send(make_item(scpt_pkg::ActAdd, 0, 0, 64'h0a01_0000, 16, 16'h0022));
        send(make_item(scpt_pkg::ActAdd, 0, 0, 64'hffff_ffff, 32, 16'hffff));
        send(make_item(scpt_pkg::ActAdd, 0, 0, 64'h8000_0000, 1, 16'h0001));
        send(make_item(scpt_pkg::ActAdd, 0, 0, 64'h0a00_0000, 0, 16'h0005));
        send(make_item(scpt_pkg::ActAdd, 0, 0, 64'h0a00_0000, 33, 16'h0005));
        send(make_item(scpt_pkg::ActAdd, 1, '1, '1, 128, 16'h1234));
        send(make_item(scpt_pkg::ActAdd, 1, 64'h2001_0db8_0000_0000, 0, 32, 16'h4321));
        send(make_item(scpt_pkg::ActAdd, 1, 0, 0, 129, 16'h0));
        send(make_item(scpt_pkg::ActDelete, 1, 0, 0, 255, 16'h0));
        send(make_item(scpt_pkg::ActLookup, 0, 0, 64'h0a01_0203, 0, 0));
        send(make_item(scpt_pkg::ActLookup, 0, 0, 64'h0a02_0203, 0, 0));
        send(make_item(scpt_pkg::ActLookup, 0, 0, 64'h0b00_0000, 0, 0));
        send(make_item(scpt_pkg::ActLookup, 1, 64'h2001_0db8_ffff_0000, 5, 0, 0));
        send(make_item(scpt_pkg::ActLookup, 1, '1, '1, 0, 0));
        send(make_item(scpt_pkg::ActAdd, 0, 0, 64'h0a00_0000, 8, 16'h00aa));
        send(make_item(scpt_pkg::ActLookup, 0, 0, 64'h0a02_0203, 0, 0));
        send(make_item(scpt_pkg::ActDelete, 0, 0, 64'h0a01_0000, 16, 0));
        send(make_item(scpt_pkg::ActDelete, 0, 0, 64'h0a01_0000, 16, 0));
        send(make_item(scpt_pkg::ActNone, 1, '1, '1, 8'hff, 16'hffff));
        send(make_item(scpt_pkg::ActLookup, 0, 0, 64'h0a01_0203, 0, 0));

        for (int n = 0; n < 400; n++) send(random_item(90, 3, 10));
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        no_idle = 1;
        for (int n = 0; n < 150; n++) send(random_item(30, 40, 45));
        no_idle = 0;
        for (int n = 0; n < 130; n++) send(random_item(25, 45, 45));
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/scpt_pkg.sv
rtl/core/sorted_cidr_priority_table.sv
tb/tb_top.sv
